// ----- sv/dmm_pkg.sv -----
// ----------------------------------------------------------------------------
// Dense matrix multiply package
// Shared sizes, codes and types for the dense matrix multiply unit.
// ----------------------------------------------------------------------------
package dmm_pkg;

  localparam int MAX_DIM     = 16;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(MAX_DIM);
  localparam int DIM_W       = 5;
  localparam int IDX_W       = CNT_W + DIM_W + 1;
  localparam int VAL_W       = 16;
  localparam int PROD_W      = 2 * VAL_W;
  localparam int SUM_W       = 36;
  localparam int ROW_W       = 4;
  localparam int COL_W       = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 5;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);

  localparam logic [1:0] MODE_LOAD_A  = 2'd0;
  localparam logic [1:0] MODE_LOAD_B  = 2'd1;
  localparam logic [1:0] MODE_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_C       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_TRANSPOSED = 3'd3;

  typedef enum logic [1:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_COMPUTE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [ADDR_W-1:0]  address;
    logic [VAL_W-1:0]   value;
    logic [ROW_W-1:0]   row;
  } cmd_t;

  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] inner;
    logic             trans;
  } cfg_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] lim;
    lim = DIM_W'(MAX_DIM);
    return (v > lim) ? lim : v;
  endfunction

endpackage

// ----- sv/dmm_if.sv -----
// ----------------------------------------------------------------------------
// Dense matrix multiply channels
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
interface dmm_in_if import dmm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [ADDR_W-1:0] address;
  logic [VAL_W-1:0]  value;
  logic [ROW_W-1:0]  row;

  modport source (output valid, mode, address, value, row, input ready);
  modport sink (input valid, mode, address, value, row, output ready);
endinterface

interface dmm_out_if import dmm_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] sum;
  logic [COL_W-1:0]        column;
  logic                    last;

  modport source (output valid, sum, column, last, input ready);
  modport sink (input valid, sum, column, last, output ready);
endinterface

interface dmm_cfg_if import dmm_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/dmm_front.sv -----
// ----------------------------------------------------------------------------
// Dense matrix multiply front end
// Accepts input words, drops those that yield nothing and queues the rest.
// ----------------------------------------------------------------------------
module dmm_front import dmm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  dmm_in_if.sink      in_ch,
  output cmd_t        cmd,
  output logic        cmd_valid,
  input  logic        cmd_ready
);

  cmd_t              q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              keep;
  cmd_t              new_cmd;
  logic              push;
  logic              pop;

  always_comb begin
    keep             = 1'b0;
    new_cmd.kind     = CMD_LOAD_A;
    new_cmd.address  = in_ch.address;
    new_cmd.value    = in_ch.value;
    new_cmd.row      = in_ch.row;
    case (in_ch.mode)
      MODE_LOAD_A: begin
        keep         = 1'b1;
        new_cmd.kind = CMD_LOAD_A;
      end
      MODE_LOAD_B: begin
        keep         = 1'b1;
        new_cmd.kind = CMD_LOAD_B;
      end
      MODE_COMPUTE: begin
        keep         = ({1'b0, in_ch.row} < cfg.rows) && (cfg.cols != '0);
        new_cmd.kind = CMD_COMPUTE;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ch.ready = (count_r != (QPTR_W+1)'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready && keep;
  assign cmd_valid   = (count_r != '0);
  assign pop         = cmd_valid && cmd_ready;
  assign cmd         = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

// ----- sv/dmm_back.sv -----
// ----------------------------------------------------------------------------
// Dense matrix multiply back end
// Holds both matrices, carries out loads and runs the multiply-accumulate.
// ----------------------------------------------------------------------------
module dmm_back import dmm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  cmd_t        cmd,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  dmm_out_if.source   out_ch
);

  typedef enum logic {
    ST_IDLE,
    ST_ISSUE
  } state_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             lastk;
    logic             kill;
    logic [COL_W-1:0] col;
    logic             lastj;
  } tag_t;

  logic [VAL_W-1:0] mem_a [STORE_DEPTH];
  logic [VAL_W-1:0] mem_b [STORE_DEPTH];

  state_t                   state_r;
  logic [CNT_W-1:0]         k_r;
  logic [CNT_W-1:0]         j_r;
  logic [ROW_W-1:0]         row_r;
  tag_t                     s1_r, s2_r, s1_nxt;
  logic signed [VAL_W-1:0]  rd_a_r, rd_b_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  acc_r, acc_nxt;
  logic                     out_valid_r;
  logic signed [SUM_W-1:0]  out_sum_r;
  logic [COL_W-1:0]         out_col_r;
  logic                     out_last_r;

  logic              adv;
  logic              issue;
  logic              pop;
  logic              lastk;
  logic              lastj;
  logic              zero_inner;
  logic [IDX_W-1:0]  ia_wide, ib_wide;
  logic [ADDR_W-1:0] ia, ib;

  assign adv        = !out_valid_r || out_ch.ready;
  assign cmd_ready  = (state_r == ST_IDLE);
  assign pop        = cmd_valid && cmd_ready;
  assign issue      = (state_r == ST_ISSUE) && adv;
  assign zero_inner = (cfg.inner == '0);
  assign lastk      = zero_inner || ({1'b0, k_r} == cfg.inner - 1'b1);
  assign lastj      = ({1'b0, j_r} == cfg.cols - 1'b1);

  always_comb begin
    ia_wide = IDX_W'(k_r) + IDX_W'(row_r) * IDX_W'(cfg.inner);
    if (cfg.trans) begin
      ib_wide = IDX_W'(k_r) + IDX_W'(j_r) * IDX_W'(cfg.inner);
    end else begin
      ib_wide = IDX_W'(j_r) + IDX_W'(k_r) * IDX_W'(cfg.cols);
    end
    ia = ia_wide[ADDR_W-1:0];
    ib = ib_wide[ADDR_W-1:0];

    s1_nxt.valid = issue;
    s1_nxt.first = (k_r == '0);
    s1_nxt.lastk = lastk;
    s1_nxt.kill  = zero_inner;
    s1_nxt.col   = j_r;
    s1_nxt.lastj = lastj;

    acc_nxt = (s2_r.first ? SUM_W'(0) : acc_r) + SUM_W'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (pop && cmd.kind == CMD_LOAD_A) begin
      mem_a[cmd.address] <= cmd.value;
    end
    if (pop && cmd.kind == CMD_LOAD_B) begin
      mem_b[cmd.address] <= cmd.value;
    end
    if (issue) begin
      rd_a_r <= mem_a[ia];
      rd_b_r <= mem_b[ib];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      j_r     <= '0;
      row_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (pop && cmd.kind == CMD_COMPUTE) begin
            state_r <= ST_ISSUE;
            k_r     <= '0;
            j_r     <= '0;
            row_r   <= cmd.row;
          end
        end
        ST_ISSUE: begin
          if (adv) begin
            if (lastk) begin
              k_r <= '0;
              if (lastj) begin
                state_r <= ST_IDLE;
              end else begin
                j_r <= j_r + 1'b1;
              end
            end else begin
              k_r <= k_r + 1'b1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r        <= '0;
      s2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        s1_r <= s1_nxt;
        s2_r <= s1_r;
      end
      if (adv && s2_r.valid && s2_r.lastk) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= s1_r.kill ? PROD_W'(0) : rd_a_r * rd_b_r;
      if (s2_r.valid) begin
        acc_r <= acc_nxt;
      end
      if (s2_r.valid && s2_r.lastk) begin
        out_sum_r  <= acc_nxt;
        out_col_r  <= s2_r.col;
        out_last_r <= s2_r.lastj;
      end
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.sum    = out_sum_r;
  assign out_ch.column = out_col_r;
  assign out_ch.last   = out_last_r;

endmodule

// ----- sv/dense_matrix_multiply_unit.sv -----
// ----------------------------------------------------------------------------
// Dense matrix multiply unit
// Computes rows of C = A*B from matrices loaded one entry at a time.
// ----------------------------------------------------------------------------
// Input words either load one entry of A or B, or ask for one row of C.
// A row request returns one result word per column, in column order, with
// last set on the final column; a request for a row past rows_a, or with no
// columns, returns nothing, as does the unused mode.
// Loads and requests pass through a four-word queue to the compute engine,
// which runs one multiply-accumulate per cycle, while the output is not
// stalled, from single-port reads of the A and B stores. Registers are
// written over the configuration channel, which is always ready. The user
// must write registers only while the unit is idle; the unit itself does
// not enforce this.
// Reset clears the queue, the engine and the output, and sets the registers
// to 16 rows, 16 columns, inner length 16 and B stored row by row. Matrix
// entries hold nothing defined until loaded.
// A stalled receiver holds the output word and freezes the engine; the
// queue keeps taking words until it is full.
// ----------------------------------------------------------------------------
module dense_matrix_multiply_unit import dmm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  dmm_in_if.sink      in_ch,
  dmm_out_if.source   out_ch,
  dmm_cfg_if.sink     cfg_ch
);

  logic [DIM_W-1:0] rows_r;
  logic [DIM_W-1:0] cols_r;
  logic [DIM_W-1:0] inner_r;
  logic             trans_r;
  cfg_t             cfg;
  cmd_t             cmd;
  logic             cmd_valid;
  logic             cmd_ready;
  logic             cfg_wr;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= DIM_W'(MAX_DIM);
      cols_r  <= DIM_W'(MAX_DIM);
      inner_r <= DIM_W'(MAX_DIM);
      trans_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_ch.index)
        CFG_ROWS_A:       rows_r  <= cfg_ch.data;
        CFG_COLS_C:       cols_r  <= cfg_ch.data;
        CFG_INNER_LEN:    inner_r <= cfg_ch.data;
        CFG_B_TRANSPOSED: trans_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  assign cfg.rows  = clamp_dim(rows_r);
  assign cfg.cols  = clamp_dim(cols_r);
  assign cfg.inner = clamp_dim(inner_r);
  assign cfg.trans = trans_r;

  dmm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  dmm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result word valid right after reset");

  a_last_column: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last) |-> ({1'b0, out_ch.column} == cfg.cols - 1'b1))
    else $error("last flag not on the final column");

  a_inner_column: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.last) |-> ({1'b0, out_ch.column} < cfg.cols - 1'b1))
    else $error("column past the end without last flag");

  a_queue_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && cmd.kind == CMD_COMPUTE) |-> ({1'b0, cmd.row} < cfg.rows))
    else $error("out-of-range row request reached the engine");
`endif

endmodule
